/* rtl/pbvt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Package for the projected box visibility test
// Shared types and constants of the controller and the datapath.
// ----------------------------------------------------------------------------
package pbvt_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_VERTEX = 1'b1
    } op_t;

    typedef struct packed {
        logic       load_vertex;
        logic       mac_clear;
        logic       mac_step;
        logic [3:0] mac_index;
        logic       row_latch;
        logic       div_start;
        logic [1:0] div_axis;
        logic       box_update;
        logic       fault_set;
        logic       report;
        logic       box_clear;
    } pbvt_cmd_t;

    typedef struct packed {
        logic w_zero;
        logic div_done;
    } pbvt_sts_t;

endpackage
`default_nettype wire

/* rtl/pbvt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Projected box visibility test controller
// Sequences sixteen multiply-accumulates, three divisions and the report.
// ----------------------------------------------------------------------------
module pbvt_ctrl
    import pbvt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      start,
    input  wire logic      last_in,
    input  wire logic      out_busy,
    input  pbvt_sts_t      sts,
    output logic           busy,
    output pbvt_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_CHECK,
        ST_DIV,
        ST_DIVWAIT,
        ST_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic [1:0] axis_reg, axis_next;
    logic       last_reg, last_next;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        axis_next  = axis_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.mac_index = idx_reg;
        cmd.div_axis  = axis_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cmd.load_vertex = 1'b1;
                    cmd.mac_clear   = 1'b1;
                    idx_next   = 4'd0;
                    last_next  = last_in;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                cmd.mac_step = 1'b1;
                if (idx_reg[1:0] == 2'd3) begin
                    cmd.row_latch = 1'b1;
                end
                idx_next = idx_reg + 4'd1;
                if (idx_reg == 4'd15) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                axis_next = 2'd0;
                if (sts.w_zero) begin
                    cmd.fault_set = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT: begin
                if (sts.div_done) begin
                    cmd.box_update = 1'b1;
                    axis_next = axis_reg + 2'd1;
                    state_next = (axis_reg == 2'd2) ? ST_FINISH : ST_DIV;
                end
            end
            ST_FINISH: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (!out_busy) begin
                    cmd.report    = 1'b1;
                    cmd.box_clear = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= 4'd0;
            axis_reg  <= 2'd0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            axis_reg  <= axis_next;
            last_reg  <= last_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/pbvt_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Projected box visibility test divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pbvt_div
    import pbvt_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic                   done,
    output logic signed [31:0]     quot
);

    localparam int unsigned NW = DATA_W + FRAC_BITS;
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] n_reg, n_next;
    logic [NW:0]   r_reg, r_next;
    logic [31:0]   d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next, neg_reg, neg_next;
    logic          fin_reg;
    logic [NW:0]   trial;
    logic [NW-1:0] qsig;

    always_comb begin
        n_next = n_reg; r_next = r_reg; d_next = d_reg;
        cnt_next = cnt_reg; run_next = run_reg; neg_next = neg_reg;
        trial = {r_reg[NW-1:0], n_reg[NW-1]};
        if (start) begin
            n_next   = {(num[31] ? 32'(-num) : 32'(num)), {FRAC_BITS{1'b0}}};
            d_next   = den[31] ? 32'(-den) : 32'(den);
            neg_next = num[31] ^ den[31];
            r_next   = '0;
            cnt_next = CW'(NW);
            run_next = 1'b1;
        end else if (run_reg) begin
            if (trial >= {{(NW-31){1'b0}}, d_reg}) begin
                r_next = trial - {{(NW-31){1'b0}}, d_reg};
                n_next = {n_reg[NW-2:0], 1'b1};
            end else begin
                r_next = trial;
                n_next = {n_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                run_next = 1'b0;
            end
        end
    end

    assign qsig = neg_reg ? (~n_reg + NW'(1)) : n_reg;

    always_comb begin
        if (!neg_reg && n_reg > NW'(32'h7FFFFFFF)) begin
            quot = 32'sh7FFFFFFF;
        end else if (neg_reg && n_reg > NW'(33'h80000000)) begin
            quot = 32'sh80000000;
        end else begin
            quot = qsig[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            fin_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
            fin_reg <= run_reg && (cnt_reg == CW'(1));
        end
        n_reg   <= n_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = fin_reg;

endmodule
`default_nettype wire

/* rtl/pbvt_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Projected box visibility test datapath
// Matrix store, shared multiply-accumulate, divider and bounding box.
// ----------------------------------------------------------------------------
module pbvt_datapath
    import pbvt_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               mat_we,
    input  wire logic [3:0]         mat_idx,
    input  wire logic signed [31:0] mat_val,
    input  wire logic signed [31:0] vx,
    input  wire logic signed [31:0] vy,
    input  wire logic signed [31:0] vz,
    input  pbvt_cmd_t               cmd,
    output pbvt_sts_t               sts,
    output logic                    visible,
    output logic                    fault
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] SMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SMIN = 32'sh80000000;

    logic signed [31:0] mat_reg [16];
    logic signed [31:0] v_reg [4];
    logic signed [31:0] p_reg [4];
    logic signed [49:0] acc_reg;
    logic signed [31:0] min_reg [3];
    logic signed [31:0] max_reg [3];
    logic               fault_reg;
    logic signed [63:0] prod;
    logic signed [49:0] acc_sum;
    logic signed [31:0] acc_sat;
    logic signed [31:0] q;
    logic               div_done;

    assign prod    = 64'(mat_reg[cmd.mac_index]) * 64'(v_reg[cmd.mac_index[1:0]]);
    assign acc_sum = acc_reg + 50'(prod >>> FRAC_BITS);
    assign acc_sat = (acc_sum > 50'(SMAX)) ? SMAX :
                     (acc_sum < 50'(SMIN)) ? SMIN : acc_sum[31:0];

    pbvt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (p_reg[cmd.div_axis]),
        .den     (p_reg[3]),
        .done    (div_done),
        .quot    (q)
    );

    assign sts.w_zero   = (p_reg[3] == '0);
    assign sts.div_done = div_done;

    always_comb begin
        logic ax0, ax1, ax2;
        ax0 = (min_reg[0] < 0 && max_reg[0] > 0) ||
              (min_reg[0] >= -ONE && min_reg[0] <= ONE) ||
              (max_reg[0] >= -ONE && max_reg[0] <= ONE);
        ax1 = (min_reg[1] < 0 && max_reg[1] > 0) ||
              (min_reg[1] >= -ONE && min_reg[1] <= ONE) ||
              (max_reg[1] >= -ONE && max_reg[1] <= ONE);
        ax2 = (min_reg[2] < 0 && max_reg[2] > 0) ||
              (min_reg[2] >= 0 && min_reg[2] <= ONE) ||
              (max_reg[2] >= 0 && max_reg[2] <= ONE);
        visible = ax0 && ax1 && ax2;
    end
    assign fault = fault_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) mat_reg[i] <= '0;
            for (int a = 0; a < 3; a++) begin
                min_reg[a] <= SMAX;
                max_reg[a] <= SMIN;
            end
            fault_reg <= 1'b0;
        end else begin
            if (mat_we) mat_reg[mat_idx] <= mat_val;
            if (cmd.fault_set) fault_reg <= 1'b1;
            if (cmd.box_update) begin
                if (q < min_reg[cmd.div_axis]) min_reg[cmd.div_axis] <= q;
                if (q > max_reg[cmd.div_axis]) max_reg[cmd.div_axis] <= q;
            end
            if (cmd.box_clear) begin
                for (int a = 0; a < 3; a++) begin
                    min_reg[a] <= SMAX;
                    max_reg[a] <= SMIN;
                end
                fault_reg <= 1'b0;
            end
        end
        if (cmd.load_vertex) begin
            v_reg[0] <= vx;
            v_reg[1] <= vy;
            v_reg[2] <= vz;
            v_reg[3] <= ONE;
        end
        if (cmd.mac_clear) begin
            acc_reg <= '0;
        end else if (cmd.mac_step) begin
            acc_reg <= cmd.row_latch ? '0 : acc_sum;
            if (cmd.row_latch) p_reg[cmd.mac_index[3:2]] <= acc_sat;
        end
    end

endmodule
`default_nettype wire

/* rtl/projected_box_visibility_test.sv */
`default_nettype none
// Sequence: a vertex holds the input through sixteen multiply-accumulates, a w check,
// three divisions in the shared restoring divider and a finish state. A zero w skips
// the divisions.
// Throughput: one vertex at a time; a report that is not taken stalls the block.
// Reset: synchronous, clears the matrix to zero and empties the box.
// ----------------------------------------------------------------------------
// Projected box visibility test
// Projects mesh vertices through a 4x4 matrix and culls the clip-space box.
// ----------------------------------------------------------------------------
module projected_box_visibility_test
    import pbvt_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: element_index, element_value, vert_x, vert_y, vert_z, pad
    input  wire logic [135:0] s_tdata,
    // tuser: operation
    input  wire logic         s_tuser,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: visible, divide_fault, pad
    output logic [7:0]        m_tdata
);

    pbvt_cmd_t cmd;
    pbvt_sts_t sts;
    logic      busy, acc, vis, flt;
    logic      mv_reg;
    logic [1:0] md_reg;

    assign s_tready = !busy;
    assign acc      = s_tvalid && s_tready;

    pbvt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (acc && s_tuser == OP_VERTEX),
        .last_in  (s_tlast),
        .out_busy (mv_reg && !m_tready),
        .sts      (sts),
        .busy     (busy),
        .cmd      (cmd)
    );

    pbvt_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mat_we  (acc && s_tuser == OP_LOAD),
        .mat_idx (s_tdata[3:0]),
        .mat_val (s_tdata[35:4]),
        .vx      (s_tdata[67:36]),
        .vy      (s_tdata[99:68]),
        .vz      (s_tdata[131:100]),
        .cmd     (cmd),
        .sts     (sts),
        .visible (vis),
        .fault   (flt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cmd.report) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
        if (cmd.report) md_reg <= {flt, vis};
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {6'd0, md_reg};

endmodule
`default_nettype wire
